@@ rtl/core/lpf_pkg.sv @@
// Shared types and constants for the largest prime factor block.
`timescale 1ns / 1ps

package lpf_pkg;

	// Port widths of the input number and the result factor
	localparam int IN_BITS  = 32;
	localparam int OUT_BITS = 32;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STRIP,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DONE
	} lpf_state_t;

	// Handshake between the sequencer and the shared divider
	typedef struct packed {
		logic start;
	} lpf_div_req_t;

	typedef struct packed {
		logic done;
	} lpf_div_rsp_t;

endpackage

@@ rtl/core/lpf_divider.sv @@
// Shared restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module lpf_divider #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpf_pkg::lpf_div_req_t req,
	output lpf_pkg::lpf_div_rsp_t rsp,
	input  logic [W-1:0]          dividend,
	input  logic [W-1:0]          divisor,
	output logic [W-1:0]          quotient,
	output logic [W-1:0]          remainder
);
	import lpf_pkg::*;

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  quo_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		trial = {acc_q, quo_q[W-1]};
		diff  = trial - {1'b0, divisor};
		ge    = (trial >= {1'b0, divisor});
	end

	// Control: run W steps after a start, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: shift in dividend bits, keep remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			acc_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign rsp.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = acc_q;

endmodule

@@ rtl/core/largest_prime_factor_trial_division.sv @@
// Top level: largest prime factor of an unsigned number by trial division.
`timescale 1ns / 1ps

// Usage:
//   Input channel in_valid/in_ready carries value; a transfer starts one job.
//   The number is taken modulo 2^VALUE_WIDTH. Output channel out_valid/out_ready
//   carries largest_factor (low 32 bits) and zero_error (set for a zero input,
//   factor then 0). An input of 1 returns 1.
//   Timing: factors of two are stripped one bit per cycle (none for an odd
//   number). The shared restoring divider makes one pass per odd trial
//   divisor plus one per factor divided out; a 32-bit prime near 2^32 needs
//   about 32768 passes.
//   One number is worked at a time: in_ready is high only while the
//   sequencer is idle. A finished result sits in the output register, so the
//   next number may start while it waits; if that job finishes before the
//   receiver takes the old result, the sequencer holds until the slot frees.
//   Reset clears the sequencer and the output valid; no result is pending.
module largest_prime_factor_trial_division #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lpf_pkg::IN_BITS-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lpf_pkg::OUT_BITS-1:0] largest_factor,
	output logic                         zero_error
);
	import lpf_pkg::*;

	localparam int W = VALUE_WIDTH;

	lpf_state_t    state_q, state_d;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  best_q;
	logic [W-1:0]  d_q;
	logic          dividing_q;
	logic          err_q;
	logic          out_valid_q;
	logic [OUT_BITS-1:0] factor_q;
	logic          zero_error_q;

	lpf_div_req_t  div_req;
	lpf_div_rsp_t  div_rsp;
	logic [W-1:0]  quo;
	logic [W-1:0]  rmd;
	logic [W-1:0]  v_in;
	logic          accept;
	logic          load_out;

	assign v_in   = W'(value);
	assign accept = in_valid && in_ready;

	// Shared divider works rem_q / d_q
	lpf_divider #(
		.W (W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.rsp       (div_rsp),
		.dividend  (rem_q),
		.divisor   (d_q),
		.quotient  (quo),
		.remainder (rmd)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer strobes
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		div_req.start = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (v_in == '0) begin
						state_d = ST_DONE;
					end else if (!v_in[0]) begin
						state_d = ST_STRIP;
					end else begin
						state_d = ST_DIV_GO;
					end
				end
			end
			ST_STRIP: begin
				if (rem_q[0]) begin
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				div_req.start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					if (!dividing_q && (d_q > quo)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_DIV_GO;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Working registers: remainder, best factor, trial divisor
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rem_q      <= v_in;
					d_q        <= W'(3);
					dividing_q <= 1'b0;
					err_q      <= (v_in == '0);
					if (v_in == '0) begin
						best_q <= '0;
					end else if (!v_in[0]) begin
						best_q <= W'(2);
					end else begin
						best_q <= v_in;
					end
				end
			end
			ST_STRIP: begin
				if (!rem_q[0]) begin
					rem_q <= rem_q >> 1;
				end
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					if (dividing_q) begin
						// Keep dividing the same divisor out until it no longer fits
						if (rmd == '0) begin
							rem_q <= quo;
						end else begin
							d_q        <= d_q + W'(2);
							dividing_q <= 1'b0;
						end
					end else if (d_q > quo) begin
						// Bound passed: the leftover remainder wins if larger
						if (rem_q > best_q) begin
							best_q <= rem_q;
						end
					end else if (rmd == '0) begin
						rem_q      <= quo;
						best_q     <= d_q;
						dividing_q <= 1'b1;
					end else begin
						d_q <= d_q + W'(2);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: hold the result until the receiver takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			factor_q     <= OUT_BITS'(best_q);
			zero_error_q <= err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign largest_factor = factor_q;
	assign zero_error     = zero_error_q;

endmodule
